// ----- rtl/core/imel_pkg.sv -----
// ----------------------------------------------------------------------------
// Isotropic metric edge length: shared package
// Constants and pipeline depths used by the edge length datapath.
// ----------------------------------------------------------------------------
package imel_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [31:0] EPS_RESET = 32'd4295;
  localparam logic [31:0] MAX32 = 32'hFFFFFFFF;

  localparam int SQRT_STEPS = 33;
  localparam int LOG_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int NUM_W = 70;

endpackage

// ----- rtl/core/iso_metric_edge_length.sv -----
// ----------------------------------------------------------------------------
// Isotropic metric edge length
// Fully pipelined edge length in an isotropic size metric, one edge per cycle unless stalled.
// ----------------------------------------------------------------------------
// The input channel carries the two endpoints and the two sizes of an edge;
// a transfer happens when in_valid is high and in_stall is low. The output
// channel carries metric_length with its overflow and invalid flags under the
// same valid and stall rule. The ratio threshold is written through wr_en
// and wr_data; the user must write it only while no edge is in flight, as
// the block does not enforce this. Each edge passes from its input transfer
// to out_valid through three setup stages, a 33-stage square root running
// beside two 32-stage logarithm units, three stages of log scaling and
// numerator forming, one saturation check, a 32-stage restoring divider and
// the output register. Unless held, the pipeline takes one edge per cycle.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall goes high in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the threshold with its default.
// ----------------------------------------------------------------------------
module iso_metric_edge_length #(
  parameter int FRAC_BITS = imel_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic [31:0]        size_start,
  input  logic [31:0]        size_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        metric_length,
  output logic               overflow,
  output logic               invalid
);

  localparam int DW = 64 - FRAC_BITS;
  localparam int NW = imel_pkg::NUM_W;
  localparam int CW = DW + 32;
  localparam int NSQ = imel_pkg::SQRT_STEPS;
  localparam int NLG = imel_pkg::LOG_STEPS;
  localparam int NDV = imel_pkg::DIV_STEPS;

  function automatic logic [32:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    d = {b[31], b} - {a[31], a};
    return d[32] ? 33'(-d) : d;
  endfunction

  function automatic logic [4:0] lead_one(logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [31:0] eps;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= imel_pkg::EPS_RESET;
    end else if (wr_en) begin
      eps <= wr_data;
    end
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage a: coordinate differences and size checks.
  logic        a_valid, a_inv;
  logic [32:0] a_d0, a_d1, a_d2;
  logic [31:0] a_h1, a_h2, a_dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d0 <= abs_diff(start_x, end_x);
      a_d1 <= abs_diff(start_y, end_y);
      a_d2 <= abs_diff(start_z, end_z);
      a_h1 <= size_start;
      a_h2 <= size_end;
      a_dh <= (size_end >= size_start) ? size_end - size_start : size_start - size_end;
      a_inv <= (size_start == '0) || (size_end == '0);
    end
  end

  // Stage b: squares, threshold product and log normalization.
  logic        b_valid, b_inv;
  logic [65:0] b_sq0, b_sq1, b_sq2;
  logic [63:0] b_prod;
  logic [31:0] b_h1, b_dh, b_m1, b_m2;
  logic [4:0]  b_p1, b_p2;
  logic [4:0]  lo1, lo2;

  assign lo1 = lead_one(a_h1);
  assign lo2 = lead_one(a_h2);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sq0 <= 66'(a_d0) * 66'(a_d0);
      b_sq1 <= 66'(a_d1) * 66'(a_d1);
      b_sq2 <= 66'(a_d2) * 66'(a_d2);
      b_prod <= 64'(eps) * 64'(a_h1);
      b_h1 <= a_h1;
      b_dh <= a_dh;
      b_p1 <= lo1;
      b_p2 <= lo2;
      b_m1 <= a_h1 << (5'd31 - lo1);
      b_m2 <= a_h2 << (5'd31 - lo2);
      b_inv <= a_inv;
    end
  end

  // Square root and logarithm pipelines; index 0 is the sum stage.
  logic        sv [0:NSQ];
  logic [65:0] s_rad [0:NSQ];
  logic [34:0] s_rem [0:NSQ];
  logic [32:0] s_root [0:NSQ];
  logic [31:0] s_m1 [0:NSQ];
  logic [31:0] s_m2 [0:NSQ];
  logic [31:0] s_f1 [0:NSQ];
  logic [31:0] s_f2 [0:NSQ];
  logic [4:0]  s_p1 [0:NSQ];
  logic [4:0]  s_p2 [0:NSQ];
  logic [31:0] s_h1 [0:NSQ];
  logic [31:0] s_dh [0:NSQ];
  logic        s_plain [0:NSQ];
  logic        s_inv [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_rad[0] <= b_sq0 + b_sq1 + b_sq2;
      s_rem[0] <= '0;
      s_root[0] <= '0;
      s_m1[0] <= b_m1;
      s_m2[0] <= b_m2;
      s_f1[0] <= '0;
      s_f2[0] <= '0;
      s_p1[0] <= b_p1;
      s_p2[0] <= b_p2;
      s_h1[0] <= b_h1;
      s_dh[0] <= b_dh;
      s_plain[0] <= (b_dh == '0) || ({b_dh, 32'd0} < b_prod);
      s_inv[0] <= b_inv;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [36:0] rem2, trial;

    assign rem2 = {s_rem[k], s_rad[k][65:64]};
    assign trial = {2'b00, s_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_rad[k+1] <= s_rad[k] << 2;
        if (rem2 >= trial) begin
          s_rem[k+1] <= 35'(rem2 - trial);
          s_root[k+1] <= {s_root[k][31:0], 1'b1};
        end else begin
          s_rem[k+1] <= 35'(rem2);
          s_root[k+1] <= {s_root[k][31:0], 1'b0};
        end
        s_p1[k+1] <= s_p1[k];
        s_p2[k+1] <= s_p2[k];
        s_h1[k+1] <= s_h1[k];
        s_dh[k+1] <= s_dh[k];
        s_plain[k+1] <= s_plain[k];
        s_inv[k+1] <= s_inv[k];
      end
    end

    if (k < NLG) begin : g_log
      logic [63:0] sq1, sq2;
      logic [32:0] t1, t2;

      assign sq1 = 64'(s_m1[k]) * 64'(s_m1[k]);
      assign sq2 = 64'(s_m2[k]) * 64'(s_m2[k]);
      assign t1 = sq1[63:31];
      assign t2 = sq2[63:31];

      always_ff @(posedge clk) begin
        if (adv) begin
          s_m1[k+1] <= t1[32] ? t1[32:1] : t1[31:0];
          s_m2[k+1] <= t2[32] ? t2[32:1] : t2[31:0];
          s_f1[k+1] <= {s_f1[k][30:0], t1[32]};
          s_f2[k+1] <= {s_f2[k][30:0], t2[32]};
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          s_m1[k+1] <= s_m1[k];
          s_m2[k+1] <= s_m2[k];
          s_f1[k+1] <= s_f1[k];
          s_f2[k+1] <= s_f2[k];
        end
      end
    end
  end

  // Stage e: log difference.
  logic        e_valid, e_plain, e_inv;
  logic [32:0] e_l;
  logic [36:0] e_dl;
  logic [31:0] e_h1, e_dh;
  logic [36:0] g1, g2;

  assign g1 = {s_p1[NSQ], s_f1[NSQ]};
  assign g2 = {s_p2[NSQ], s_f2[NSQ]};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= sv[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_l <= s_root[NSQ];
      e_dl <= (g2 >= g1) ? g2 - g1 : g1 - g2;
      e_h1 <= s_h1[NSQ];
      e_dh <= s_dh[NSQ];
      e_plain <= s_plain[NSQ];
      e_inv <= s_inv[NSQ];
    end
  end

  // Stage f: natural log scaling.
  logic        f_valid, f_plain, f_inv;
  logic [32:0] f_l;
  logic [36:0] f_lnq;
  logic [31:0] f_h1, f_dh;
  logic [63:0] ln_lo;
  logic [37:0] ln_sum;

  assign ln_lo = 64'(e_dl[31:0]) * 64'(imel_pkg::LN2_Q32);
  assign ln_sum = 38'(e_dl[36:32]) * 38'(imel_pkg::LN2_Q32) + 38'(ln_lo[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_l <= e_l;
      f_lnq <= ln_sum[36:0];
      f_h1 <= e_h1;
      f_dh <= e_dh;
      f_plain <= e_plain;
      f_inv <= e_inv;
    end
  end

  // Stage g: numerator and denominator of the final quotient.
  logic          g_valid, g_inv;
  logic [NW-1:0] g_num;
  logic [DW-1:0] g_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (f_plain) begin
        g_num <= NW'(f_l) << FRAC_BITS;
        g_den <= DW'(f_h1);
      end else begin
        g_num <= NW'(f_l) * NW'(f_lnq);
        g_den <= DW'(f_dh) << (32 - FRAC_BITS);
      end
      g_inv <= f_inv;
    end
  end

  // Divider pipeline; index 0 holds the saturation check.
  logic          dv [0:NDV];
  logic [DW-1:0] d_rem [0:NDV];
  logic [DW-1:0] d_den [0:NDV];
  logic [31:0]   d_low [0:NDV];
  logic [31:0]   d_q [0:NDV];
  logic          d_sat [0:NDV];
  logic          d_inv [0:NDV];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sat[0] <= CW'(g_num) >= {g_den, 32'd0};
      d_rem[0] <= DW'(g_num >> 32);
      d_low[0] <= g_num[31:0];
      d_den[0] <= g_den;
      d_q[0] <= '0;
      d_inv[0] <= g_inv;
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [DW:0] r2;

    assign r2 = {d_rem[k], d_low[k][31]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= {1'b0, d_den[k]}) begin
          d_rem[k+1] <= DW'(r2 - {1'b0, d_den[k]});
          d_q[k+1] <= {d_q[k][30:0], 1'b1};
        end else begin
          d_rem[k+1] <= DW'(r2);
          d_q[k+1] <= {d_q[k][30:0], 1'b0};
        end
        d_low[k+1] <= d_low[k] << 1;
        d_den[k+1] <= d_den[k];
        d_sat[k+1] <= d_sat[k];
        d_inv[k+1] <= d_inv[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_inv[NDV]) begin
        metric_length <= '0;
        overflow <= 1'b0;
      end else if (d_sat[NDV]) begin
        metric_length <= imel_pkg::MAX32;
        overflow <= 1'b1;
      end else begin
        metric_length <= d_q[NDV];
        overflow <= 1'b0;
      end
      invalid <= d_inv[NDV];
    end
  end

endmodule
